/* design/bfmi_pkg.sv */
// bfmi_pkg: constants, types and tables for the bloom filter engine
// no dependencies
`timescale 1ns / 1ps
package bfmi_pkg;

   localparam int MaxFilterBytes = 4096;
   localparam int MaxKeyBytes    = 64;
   localparam int MaxHashCount   = 50;

   localparam int FilterBits  = MaxFilterBytes * 8;
   localparam int BitIdxW     = $clog2(FilterBits);
   localparam int ByteAddrW   = $clog2(MaxFilterBytes);
   localparam int KeyAddrW    = $clog2(MaxKeyBytes);
   localparam int KeyLenW     = KeyAddrW + 1;
   localparam int HashCntW    = 6;
   localparam int FiltBytesW  = 13;

   localparam logic [31:0] MmC1  = 32'hcc9e2d51;
   localparam logic [31:0] MmC2  = 32'h1b873593;
   localparam logic [31:0] MmAdd = 32'he6546b64;
   localparam logic [31:0] MmF1  = 32'h85ebca6b;
   localparam logic [31:0] MmF2  = 32'hc2b2ae35;
   localparam logic [31:0] SeedSpan = 32'hffffffff;

   // register index, taken from paddr bit 2
   localparam logic RegNumHashes   = 1'b0;
   localparam logic RegFilterBytes = 1'b1;

   localparam logic CmdInsert   = 1'b0;
   localparam logic CmdContains = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CLEAR, ST_HSTART, ST_RDKEY, ST_GATHER, ST_K1, ST_K2, ST_K3,
      ST_H1, ST_H2, ST_TAIL, ST_F1, ST_F2, ST_F3, ST_F4, ST_F5, ST_MOD,
      ST_RDF, ST_WRF, ST_RESULT
   } state_type;

   // floor(0xffffffff / (count-1)) for count 2..63, zero for count 0 and 1
   function automatic logic [31:0] seed_step(input logic [HashCntW-1:0] cnt);
      logic [31:0] r;
      r = 32'd0;
      for (int i = 2; i < 64; i++) begin
         if (cnt == HashCntW'(i)) r = 32'(SeedSpan / 32'(i - 1));
      end
      return r;
   endfunction

endpackage

/* design/bfmi_if.sv */
// bfmi_if: valid/ready channel interfaces for requests and responses
// depends on nothing
`timescale 1ns / 1ps
interface bfmi_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] key_byte;
   logic       byte_valid;
   logic       last_byte;
   modport source (output valid, command, key_byte, byte_valid, last_byte, input ready);
   modport sink   (input valid, command, key_byte, byte_valid, last_byte, output ready);
endinterface

interface bfmi_rsp_if;
   logic valid;
   logic ready;
   logic present;
   logic status;
   modport source (output valid, present, status, input ready);
   modport sink   (input valid, present, status, output ready);
endinterface

/* design/bloom_filter_murmur_insert_query_core.sv */
// bloom_filter_murmur_insert_query_core: bloom filter engine, murmur3 x86_32 hashing
// depends on bfmi_pkg and bfmi_if
`timescale 1ns / 1ps
// usage
// req channel: one key byte per transfer; the transfer with last_byte high
// carries the command (insert or contains) and starts the operation.
// rsp channel: one transfer per last_byte request, with present and status.
// csr port: apb-style, register 0 num_hashes at 0x0, register 1 filter_bytes
// at 0x4; write only while idle.
// operation: each hash pass mixes the key through the shared 32-bit
// multiplier, then reduces the hash to a bit index with a restoring
// remainder; an overflowed key or a count of zero goes straight to the
// result, and a contains ends at its first clear bit.
// reset: after reset the block sweeps all 4096 filter bytes clear, one byte per
// cycle, while req ready stays low.
// stall: while rsp is held by the receiver the result waits in the output
// register and no new request is taken.
module bloom_filter_murmur_insert_query_core (
   input  logic        clock,
   input  logic        reset,
   bfmi_req_if.sink    req,
   bfmi_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int BW = bfmi_pkg::BitIdxW;
   localparam int AW = bfmi_pkg::ByteAddrW;
   localparam int KW = bfmi_pkg::KeyAddrW;
   localparam int LW = bfmi_pkg::KeyLenW;
   localparam int HW = bfmi_pkg::HashCntW;

   bfmi_pkg::state_type state_ff, state_in;

   logic [7:0]  key_mem [bfmi_pkg::MaxKeyBytes];
   logic [7:0]  filt_mem [bfmi_pkg::MaxFilterBytes];
   logic [7:0]  key_rd_ff, filt_rd_ff;

   logic [HW-1:0] nh_ff;
   logic [12:0]   fb_ff;
   logic [LW-1:0] klen_ff, klen_in;
   logic          kovf_ff, kovf_in;
   logic          cmd_ff, cmd_in;
   logic [HW-1:0] cnt_ff, cnt_in, hn_ff, hn_in;
   logic [31:0]   step_ff, step_in, seed_ff, seed_in;
   logic [31:0]   h_ff, h_in, k_ff, k_in;
   logic [LW-1:0] pos_ff, pos_in;
   logic [1:0]    bsel_ff, bsel_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [4:0]    mi_ff, mi_in;
   logic [15:0]   rem_ff, rem_in;
   logic [BW:0]   nbits_ff, nbits_in;
   logic          pres_ff, pres_in, stat_ff, stat_in;
   logic          ovalid_ff, ovalid_in;

   // shared multiplier
   logic [31:0] mul_a, mul_b, mul_p;
   assign mul_p = mul_a * mul_b;

   logic          key_we, filt_we;
   logic [KW-1:0] key_wa, key_ra;
   logic [AW-1:0] filt_a;
   logic [7:0]    filt_wd;
   logic          req_acc;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == bfmi_pkg::RegNumHashes) ? {26'd0, nh_ff} :
                                                                  {19'd0, fb_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         nh_ff <= '0;
         fb_ff <= 13'd4096;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[2] == bfmi_pkg::RegNumHashes) nh_ff <= csr_pwdata[HW-1:0];
         else                                        fb_ff <= csr_pwdata[12:0];
      end
   end

   always_ff @(posedge clock) begin
      if (key_we) key_mem[key_wa] <= req.key_byte;
      key_rd_ff <= key_mem[key_ra];
   end

   always_ff @(posedge clock) begin
      if (filt_we) filt_mem[filt_a] <= filt_wd;
      filt_rd_ff <= filt_mem[filt_a];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= bfmi_pkg::ST_CLEAR;
         klen_ff   <= '0;
         kovf_ff   <= 1'b0;
         clr_ff    <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         klen_ff   <= klen_in;
         kovf_ff   <= kovf_in;
         clr_ff    <= clr_in;
         ovalid_ff <= ovalid_in;
      end
      cmd_ff <= cmd_in;   cnt_ff <= cnt_in;   hn_ff <= hn_in;
      step_ff <= step_in; seed_ff <= seed_in; h_ff <= h_in;  k_ff <= k_in;
      pos_ff <= pos_in;   bsel_ff <= bsel_in; mi_ff <= mi_in; rem_ff <= rem_in;
      nbits_ff <= nbits_in; pres_ff <= pres_in; stat_ff <= stat_in;
   end

   assign req.ready   = (state_ff == bfmi_pkg::ST_IDLE) && !ovalid_ff;
   assign req_acc     = req.valid && req.ready;
   assign rsp.valid   = ovalid_ff;
   assign rsp.present = pres_ff;
   assign rsp.status  = stat_ff;

   logic [HW-1:0] cnt_sat;
   logic [12:0]   fb_sat;
   logic [LW-1:0] nblk_end;
   logic [16:0]   rem_sh;
   logic          qbit;
   logic [2:0]    bitsel;

   always_comb begin
      state_in = state_ff;
      klen_in = klen_ff; kovf_in = kovf_ff; cmd_in = cmd_ff; cnt_in = cnt_ff;
      hn_in = hn_ff; step_in = step_ff; seed_in = seed_ff; h_in = h_ff; k_in = k_ff;
      pos_in = pos_ff; bsel_in = bsel_ff; clr_in = clr_ff; mi_in = mi_ff;
      rem_in = rem_ff; nbits_in = nbits_ff; pres_in = pres_ff; stat_in = stat_ff;
      ovalid_in = ovalid_ff && !rsp.ready;
      key_we = 1'b0; key_wa = klen_ff[KW-1:0]; key_ra = pos_ff[KW-1:0];
      filt_we = 1'b0; filt_a = rem_ff[BW-1:3]; filt_wd = '0;
      mul_a = '0; mul_b = '0;
      cnt_sat = (nh_ff > HW'(bfmi_pkg::MaxHashCount)) ? HW'(bfmi_pkg::MaxHashCount) : nh_ff;
      fb_sat  = (fb_ff == 13'd0) ? 13'd1 :
                (fb_ff > 13'(bfmi_pkg::MaxFilterBytes)) ? 13'(bfmi_pkg::MaxFilterBytes) : fb_ff;
      nblk_end = {klen_ff[LW-1:2], 2'b00};
      rem_sh = {rem_ff, h_ff[31]};
      qbit = rem_sh >= {1'b0, nbits_ff};
      bitsel = rem_ff[2:0];
      unique case (state_ff)
         bfmi_pkg::ST_CLEAR: begin
            filt_we = 1'b1;
            filt_a  = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == '1) state_in = bfmi_pkg::ST_IDLE;
         end
         bfmi_pkg::ST_IDLE: begin
            if (req_acc) begin
               cmd_in = req.command;
               if (req.byte_valid) begin
                  if (klen_ff < LW'(bfmi_pkg::MaxKeyBytes)) begin
                     key_we  = 1'b1;
                     klen_in = klen_ff + 1'b1;
                  end else begin
                     kovf_in = 1'b1;
                  end
               end
               if (req.last_byte) state_in = bfmi_pkg::ST_HSTART;
            end
         end
         bfmi_pkg::ST_HSTART: begin
            cnt_in = cnt_sat;
            step_in = bfmi_pkg::seed_step(cnt_sat);
            nbits_in = {fb_sat, 3'b000};
            hn_in = '0; seed_in = '0; pres_in = 1'b1; stat_in = 1'b0;
            if (kovf_ff) begin
               pres_in = 1'b0; stat_in = 1'b1; state_in = bfmi_pkg::ST_RESULT;
            end else if (cnt_sat == '0) begin
               state_in = bfmi_pkg::ST_RESULT;
            end else begin
               h_in = '0; pos_in = '0; bsel_in = '0; k_in = '0;
               state_in = bfmi_pkg::ST_RDKEY;
            end
         end
         bfmi_pkg::ST_RDKEY: begin
            // start of a hash pass or next byte fetch
            if (pos_ff == '0 && bsel_ff == '0 && k_ff == '0) h_in = seed_ff;
            if (pos_ff < klen_ff) state_in = bfmi_pkg::ST_GATHER;
            else if (klen_ff[1:0] != 2'd0) state_in = bfmi_pkg::ST_K1;
            else state_in = bfmi_pkg::ST_TAIL;
         end
         bfmi_pkg::ST_GATHER: begin
            unique case (bsel_ff)
               2'd0: k_in = {24'd0, key_rd_ff};
               2'd1: k_in = k_ff | {16'd0, key_rd_ff, 8'd0};
               2'd2: k_in = k_ff | {8'd0, key_rd_ff, 16'd0};
               default: k_in = k_ff | {key_rd_ff, 24'd0};
            endcase
            pos_in = pos_ff + 1'b1;
            bsel_in = bsel_ff + 1'b1;
            if (bsel_ff == 2'd3 || pos_ff + 1'b1 == klen_ff) state_in = bfmi_pkg::ST_K1;
            else state_in = bfmi_pkg::ST_RDKEY;
            if (pos_ff == '0 && bsel_ff == '0) h_in = seed_ff;
         end
         bfmi_pkg::ST_K1: begin
            mul_a = k_ff; mul_b = bfmi_pkg::MmC1;
            k_in = mul_p;
            state_in = bfmi_pkg::ST_K2;
         end
         bfmi_pkg::ST_K2: begin
            mul_a = {k_ff[16:0], k_ff[31:17]}; mul_b = bfmi_pkg::MmC2;
            k_in = mul_p;
            state_in = bfmi_pkg::ST_K3;
         end
         bfmi_pkg::ST_K3: begin
            h_in = h_ff ^ k_ff;
            if (pos_ff <= nblk_end && bsel_ff == 2'd0) state_in = bfmi_pkg::ST_H1;
            else state_in = bfmi_pkg::ST_TAIL;
         end
         bfmi_pkg::ST_H1: begin
            mul_a = {h_ff[18:0], h_ff[31:19]}; mul_b = 32'd5;
            h_in = mul_p + bfmi_pkg::MmAdd;
            k_in = '0;
            state_in = bfmi_pkg::ST_RDKEY;
         end
         bfmi_pkg::ST_TAIL: begin
            h_in = h_ff ^ {{(32-LW){1'b0}}, klen_ff};
            state_in = bfmi_pkg::ST_F1;
         end
         bfmi_pkg::ST_F1: begin
            mul_a = h_ff ^ {16'd0, h_ff[31:16]}; mul_b = bfmi_pkg::MmF1;
            h_in = mul_p;
            state_in = bfmi_pkg::ST_F2;
         end
         bfmi_pkg::ST_F2: begin
            mul_a = h_ff ^ {13'd0, h_ff[31:13]}; mul_b = bfmi_pkg::MmF2;
            h_in = mul_p;
            state_in = bfmi_pkg::ST_F3;
         end
         bfmi_pkg::ST_F3: begin
            h_in = h_ff ^ {16'd0, h_ff[31:16]};
            rem_in = '0; mi_in = '0;
            state_in = bfmi_pkg::ST_MOD;
         end
         bfmi_pkg::ST_MOD: begin
            // restoring remainder, one bit per cycle
            rem_in = qbit ? 16'(rem_sh - {1'b0, nbits_ff}) : rem_sh[15:0];
            h_in = {h_ff[30:0], 1'b0};
            mi_in = mi_ff + 1'b1;
            if (mi_ff == 5'd31) state_in = bfmi_pkg::ST_F4;
         end
         bfmi_pkg::ST_F4: begin
            state_in = bfmi_pkg::ST_F5;
         end
         bfmi_pkg::ST_F5: begin
            state_in = bfmi_pkg::ST_RDF;
         end
         bfmi_pkg::ST_RDF: begin
            state_in = bfmi_pkg::ST_WRF;
         end
         bfmi_pkg::ST_WRF: begin
            if (cmd_ff == bfmi_pkg::CmdInsert) begin
               filt_we = 1'b1;
               filt_wd = filt_rd_ff | (8'd1 << bitsel);
            end else if (filt_rd_ff[bitsel] == 1'b0) begin
               pres_in = 1'b0;
            end
            hn_in = hn_ff + 1'b1;
            seed_in = seed_ff + step_ff;
            pos_in = '0; bsel_in = '0; k_in = '0; h_in = '0;
            if ((hn_ff + 1'b1 == cnt_ff) ||
                (cmd_ff == bfmi_pkg::CmdContains && filt_rd_ff[bitsel] == 1'b0))
               state_in = bfmi_pkg::ST_RESULT;
            else
               state_in = bfmi_pkg::ST_RDKEY;
         end
         bfmi_pkg::ST_RESULT: begin
            ovalid_in = 1'b1;
            klen_in = '0; kovf_in = 1'b0;
            state_in = bfmi_pkg::ST_IDLE;
         end
         default: state_in = bfmi_pkg::ST_IDLE;
      endcase
   end
endmodule

/* tb/sv/tb_bloom_filter_murmur_insert_query_core.sv */
// testbench for the bloom filter engine: random keys inserted and queried, checked
// against a murmur3 x86_32 predictor; depends on bfmi_pkg, bfmi_if and the core
`timescale 1ns / 1ps
module tb_bloom_filter_murmur_insert_query_core;

   class bloom_scoreboard;
      bit [7:0]  key_bytes[bfmi_pkg::MaxKeyBytes];
      int        key_len;
      bit        key_ovf;
      bit [7:0]  filt[bfmi_pkg::MaxFilterBytes];
      bit [5:0]  hash_cnt;
      bit [12:0] filt_bytes;
      bit [1:0]  pending[$];
      int        errors;
      int        results;
      int        inserts;
      int        hits;
      int        overflows;

      function new();
         hash_cnt = 0;
         filt_bytes = 13'd4096;
         foreach (filt[i]) filt[i] = 0;
         key_len = 0;
         key_ovf = 0;
         errors = 0;
         results = 0;
         inserts = 0;
         hits = 0;
         overflows = 0;
      endfunction

      function bit [31:0] rotl(bit [31:0] x, int r);
         return (x << r) | (x >> (32 - r));
      endfunction

      function bit [31:0] mix(bit [31:0] k);
         k = k * bfmi_pkg::MmC1;
         k = rotl(k, 15);
         return k * bfmi_pkg::MmC2;
      endfunction

      function bit [31:0] murmur3(bit [31:0] seed);
         bit [31:0] h;
         bit [31:0] k;
         int        nblk;
         int        rem;
         h = seed;
         nblk = key_len / 4;
         rem = key_len % 4;
         for (int i = 0; i < nblk; i++) begin
            k = {key_bytes[4*i+3], key_bytes[4*i+2], key_bytes[4*i+1], key_bytes[4*i]};
            h = h ^ mix(k);
            h = rotl(h, 13);
            h = h * 5 + bfmi_pkg::MmAdd;
         end
         k = 0;
         if (rem >= 3) k = k ^ (32'(key_bytes[nblk*4+2]) << 16);
         if (rem >= 2) k = k ^ (32'(key_bytes[nblk*4+1]) << 8);
         if (rem >= 1) begin
            k = k ^ 32'(key_bytes[nblk*4]);
            h = h ^ mix(k);
         end
         h = h ^ 32'(key_len);
         h = h ^ (h >> 16);
         h = h * bfmi_pkg::MmF1;
         h = h ^ (h >> 13);
         h = h * bfmi_pkg::MmF2;
         h = h ^ (h >> 16);
         return h;
      endfunction

      function void note_request(bit cmd, bit [7:0] b, bit bv, bit lb);
         bit [31:0] cnt;
         bit [31:0] nbytes;
         bit [31:0] stp;
         bit [31:0] idx;
         bit        pres;
         if (bv) begin
            if (key_len < bfmi_pkg::MaxKeyBytes) begin
               key_bytes[key_len] = b;
               key_len++;
            end else key_ovf = 1;
         end
         if (!lb) return;
         pres = 1;
         if (key_ovf) begin
            pending.push_back(2'b01);
            overflows++;
         end else begin
            cnt = (hash_cnt > bfmi_pkg::MaxHashCount) ? 32'(bfmi_pkg::MaxHashCount) :
                                                        32'(hash_cnt);
            nbytes = (filt_bytes == 0) ? 32'd1 : 32'(filt_bytes);
            if (nbytes > bfmi_pkg::MaxFilterBytes) nbytes = bfmi_pkg::MaxFilterBytes;
            stp = (cnt > 1) ? bfmi_pkg::SeedSpan / (cnt - 1) : 32'd0;
            for (int n = 0; n < cnt; n++) begin
               idx = murmur3(32'(n) * stp) % (nbytes * 8);
               if (cmd == bfmi_pkg::CmdInsert) filt[idx >> 3][idx[2:0]] = 1;
               else if (!filt[idx >> 3][idx[2:0]]) begin
                  pres = 0;
                  break;
               end
            end
            if (cmd == bfmi_pkg::CmdInsert) inserts++;
            else if (pres) hits++;
            pending.push_back({pres, 1'b0});
         end
         key_len = 0;
         key_ovf = 0;
      endfunction

      function void check_response(bit pres, bit stat);
         bit [1:0] exp;
         results++;
         if (pending.size() == 0) begin
            $display("%0t: response with none expected: present %0b status %0b",
                     $time, pres, stat);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (exp[1] !== pres) begin
            $display("%0t: present mismatch: expected %0b actual %0b", $time, exp[1], pres);
            errors++;
         end
         if (exp[0] !== stat) begin
            $display("%0t: status mismatch: expected %0b actual %0b", $time, exp[0], stat);
            errors++;
         end
      endfunction
   endclass

   localparam logic [2:0] AddrNumHashes   = {bfmi_pkg::RegNumHashes, 2'b00};
   localparam logic [2:0] AddrFilterBytes = {bfmi_pkg::RegFilterBytes, 2'b00};

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   bit          quiet;
   int          cycles;
   int          items;

   bfmi_req_if req_if ();
   bfmi_rsp_if rsp_if ();
   bloom_scoreboard sb;

   bloom_filter_murmur_insert_query_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if.sink),
      .rsp         (rsp_if.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 0;
   always #10 clock = ~clock;

   initial begin
      sb = new();
      reset = 1;
      req_if.valid = 0;
      req_if.command = 0;
      req_if.key_byte = 0;
      req_if.byte_valid = 0;
      req_if.last_byte = 0;
      rsp_if.ready = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = 0;
      csr_pwdata = 0;
   end

   // response side: random stall bursts, checks on each transfer
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.present, rsp_if.status);
   end

   initial begin
      int n;
      @(posedge clock);
      while (1) begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 0;
            n = $urandom_range(1, 5);
            repeat (n) @(posedge clock);
         end else begin
            rsp_if.ready <= 1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 4000000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      if (addr == AddrNumHashes) sb.hash_cnt = data[5:0];
      else if (addr == AddrFilterBytes) sb.filt_bytes = data[12:0];
      @(posedge clock);
   endtask

   task automatic send_item(input bit cmd, input bit [7:0] b, input bit bv, input bit lb);
      int n;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 0;
         n = $urandom_range(1, 5);
         repeat (n) @(posedge clock);
      end
      req_if.valid <= 1;
      req_if.command <= cmd;
      req_if.key_byte <= b;
      req_if.byte_valid <= bv;
      req_if.last_byte <= lb;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_request(cmd, b, bv, lb);
      items++;
   endtask

   // one key of given length; a trailing empty last item when split_last is set or len is zero
   task automatic send_key(input bit cmd, input int len, input bit split_last,
                           input bit [7:0] base, input bit fixed);
      bit [7:0] b;
      bit       is_last;
      for (int i = 0; i < len; i++) begin
         b = fixed ? base + 8'(i) : 8'($urandom_range(0, 255));
         is_last = (i == len - 1) && !split_last;
         send_item(is_last ? cmd : 1'($urandom_range(0, 1)), b, 1, is_last);
      end
      if (split_last || len == 0) send_item(cmd, 8'($urandom_range(0, 255)), 0, 1);
      req_if.valid <= 0;
      @(posedge clock);
   endtask

   task automatic settle();
      req_if.valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (3000) @(posedge clock);
   endtask

   initial begin
      bit [7:0] kb;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: zero hashes, empty key, extremes, overflow
      send_key(bfmi_pkg::CmdContains, 0, 1, 0, 1);
      send_key(bfmi_pkg::CmdInsert, 4, 0, 8'hfc, 1);
      settle();
      csr_write(AddrNumHashes, 32'd3);
      csr_write(AddrFilterBytes, 32'd4096);
      send_key(bfmi_pkg::CmdInsert, 0, 1, 0, 1);
      send_key(bfmi_pkg::CmdContains, 0, 1, 0, 1);
      send_key(bfmi_pkg::CmdInsert, 7, 1, 8'h00, 1);
      send_key(bfmi_pkg::CmdContains, 7, 1, 8'h00, 1);
      send_key(bfmi_pkg::CmdContains, 5, 0, 8'h80, 1);
      send_key(bfmi_pkg::CmdContains, 66, 0, 8'h10, 1);
      send_key(bfmi_pkg::CmdInsert, 64, 0, 8'hc0, 1);
      send_key(bfmi_pkg::CmdContains, 64, 1, 8'hc0, 1);
      settle();
      csr_write(AddrNumHashes, 32'd63);
      csr_write(AddrFilterBytes, 32'd0);
      send_key(bfmi_pkg::CmdInsert, 3, 0, 8'hff, 1);
      send_key(bfmi_pkg::CmdContains, 2, 1, 8'h55, 1);
      settle();
      csr_write(AddrNumHashes, 32'd1);
      csr_write(AddrFilterBytes, 32'h1fff);
      send_key(bfmi_pkg::CmdInsert, 1, 0, 8'haa, 1);
      send_key(bfmi_pkg::CmdContains, 1, 0, 8'haa, 1);
      settle();

      // random phases across settings
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin csr_write(AddrNumHashes, 32'd50); csr_write(AddrFilterBytes, 32'd1); end
            1: begin csr_write(AddrNumHashes, 32'd2); csr_write(AddrFilterBytes, 32'd4); end
            2: begin
               csr_write(AddrNumHashes, 32'd0);
               csr_write(AddrFilterBytes, 32'd4096);
            end
            3: begin csr_write(AddrNumHashes, 32'd7); csr_write(AddrFilterBytes, 32'd16); end
            default: begin
               csr_write(AddrNumHashes, $urandom_range(1, 12));
               csr_write(AddrFilterBytes, $urandom_range(1, 64));
            end
         endcase
         if (ph == 7) quiet = 1;
         for (int k = 0; k < 17; k++) begin
            int len;
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(65, 70) : $urandom_range(0, 12);
            if ($urandom_range(0, 2) == 0) begin
               kb = 8'($urandom_range(0, 255));
               send_key(bfmi_pkg::CmdInsert, len, len == 0 || $urandom_range(0, 1), kb, 1);
               send_key(bfmi_pkg::CmdContains, len, len == 0 || $urandom_range(0, 1), kb, 1);
            end else
               send_key(1'($urandom_range(0, 1)), len,
                        len == 0 || $urandom_range(0, 3) == 0, 0, 0);
         end
         settle();
      end
      $display("%0d responses checked (%0d inserts, %0d contains hits, %0d overflows)",
               sb.results, sb.inserts, sb.hits, sb.overflows);
      $display("settings swept: 0..63 hashes, 0..8191 filter bytes, %0d request transfers",
               items);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
